@@ sv/m3inv_pkg.sv @@
// ---------------------------------------------------------------------------
// m3inv_pkg: shared types and constants for the 3x3 matrix inverter
// Widths of the fixed-point entries, internal precision, cofactor index map.
// ---------------------------------------------------------------------------
package m3inv_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int NENT      = 9;

  // exact internal widths
  localparam int PROD_W = 2 * WORD_BITS;              // one entry product
  localparam int COF_W  = PROD_W + 1;                 // 2x2 cofactor
  localparam int HI_W   = COF_W - WORD_BITS;          // upper slice of a cofactor
  localparam int PART_W = WORD_BITS + HI_W;           // entry times upper slice
  localparam int LO_W   = PROD_W + 1;                 // entry times lower slice
  localparam int DET_W  = WORD_BITS + COF_W + 2;      // determinant, with headroom
  localparam int NUM_W  = COF_W + 2 * FRAC_BITS;      // scaled cofactor magnitude
  localparam int QB     = WORD_BITS + 1;              // quotient bits developed

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // adjugate entry k = a[p]*a[q] - a[r]*a[s], entry index = row*3 + col
  localparam int CF_IDX [NENT][4] = '{
    '{4, 8, 7, 5}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{3, 2, 0, 5},
    '{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 3, 1}
  };

  typedef struct packed {
    logic [NENT-1:0][COF_W-1:0] cof;
    logic [DET_W-1:0]           det;
  } q_item_t;

  // one beat from the front toward the queue
  typedef struct packed {
    logic    vld;
    q_item_t item;
  } front_beat_t;

endpackage

@@ sv/matrix3_inverse.sv @@
// Throughput: one matrix per cycle, set by the 33-stage divider pipeline
// (nine restoring dividers, one quotient bit per stage) behind a 5-stage
// cofactor/determinant front. Result side cannot stall, so busy stays low.
// Reset (rst, synchronous) clears valid bits, done, and the queue pointers and fill level only.
// ---------------------------------------------------------------------------
// matrix3_inverse: 3x3 fixed-point matrix inverse via the adjugate
// Front computes cofactors and determinant, queue decouples, back divides.
// ---------------------------------------------------------------------------
module matrix3_inverse import m3inv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [WORD_BITS-1:0]  a00, a01, a02,
  input  logic [WORD_BITS-1:0]  a10, a11, a12,
  input  logic [WORD_BITS-1:0]  a20, a21, a22,
  output logic                  done,
  output logic [WORD_BITS-1:0]  inv00, inv01, inv02,
  output logic [WORD_BITS-1:0]  inv10, inv11, inv12,
  output logic [WORD_BITS-1:0]  inv20, inv21, inv22,
  output logic                  singular,
  output logic                  overflow
);

  logic [NENT-1:0][WORD_BITS-1:0] a;
  logic [NENT-1:0][WORD_BITS-1:0] inv;
  front_beat_t                    fbeat, qbeat;
  logic                           q_full;

  assign a = {a22, a21, a20, a12, a11, a10, a02, a01, a00};

  m3inv_front u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .a      (a),
    .q_full (q_full),
    .busy   (busy),
    .fo     (fbeat)
  );

  m3inv_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .fi   (fbeat),
    .full (q_full),
    .qo   (qbeat)
  );

  m3inv_back u_back (
    .clk      (clk),
    .rst      (rst),
    .qi       (qbeat),
    .done     (done),
    .inv      (inv),
    .singular (singular),
    .overflow (overflow)
  );

  assign {inv22, inv21, inv20, inv12, inv11, inv10, inv02, inv01, inv00} = inv;

endmodule

@@ sv/m3inv_front.sv @@
// ---------------------------------------------------------------------------
// m3inv_front: cofactor and determinant pipeline
// Five stages: entry products, cofactors, split determinant products,
// partial recombination, determinant sum. Stalls as a whole when held.
// ---------------------------------------------------------------------------
module m3inv_front import m3inv_pkg::*; (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [NENT-1:0][WORD_BITS-1:0]  a,
  input  logic                            q_full,
  output logic                            busy,
  output front_beat_t                     fo
);

  logic en;
  logic v1, v2, v3, v4, v5;

  logic [NENT-1:0][PROD_W-1:0]  pa1, pb1;
  logic [2:0][WORD_BITS-1:0]    r1, r2;
  logic [NENT-1:0][COF_W-1:0]   cof2, cof3, cof4, cof5;
  logic [2:0][PART_W-1:0]       hi3;
  logic [2:0][LO_W-1:0]         lo3;
  logic [2:0][DET_W-1:0]        part4;
  logic [DET_W-1:0]             det5;

  // hold everything while the finished beat cannot enter the queue
  assign en   = !(v5 && q_full);
  assign busy = !en;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
    end else if (en) begin
      v1 <= start;
      v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: products of entry pairs
      for (int k = 0; k < NENT; k++) begin
        pa1[k] <= $signed(a[CF_IDX[k][0]]) * $signed(a[CF_IDX[k][1]]);
        pb1[k] <= $signed(a[CF_IDX[k][2]]) * $signed(a[CF_IDX[k][3]]);
      end
      r1 <= a[2:0];
      // stage 2: cofactors
      for (int k = 0; k < NENT; k++) begin
        cof2[k] <= $signed({pa1[k][PROD_W-1], pa1[k]}) -
                   $signed({pb1[k][PROD_W-1], pb1[k]});
      end
      r2 <= r1;
      // stage 3: row-0 expansion, cofactor split into upper and lower slices
      for (int j = 0; j < 3; j++) begin
        hi3[j] <= $signed(r2[j]) * $signed(cof2[3*j][COF_W-1:WORD_BITS]);
        lo3[j] <= $signed(r2[j]) * $signed({1'b0, cof2[3*j][WORD_BITS-1:0]});
      end
      cof3 <= cof2;
      // stage 4: recombine slices
      for (int j = 0; j < 3; j++) begin
        part4[j] <= {{(DET_W-PART_W-WORD_BITS){hi3[j][PART_W-1]}}, hi3[j],
                     {WORD_BITS{1'b0}}} +
                    {{(DET_W-LO_W){lo3[j][LO_W-1]}}, lo3[j]};
      end
      cof4 <= cof3;
      // stage 5: determinant
      det5 <= part4[0] + part4[1] + part4[2];
      cof5 <= cof4;
    end
  end

  assign fo.vld      = v5;
  assign fo.item.cof = cof5;
  assign fo.item.det = det5;

`ifndef NO_ASSERTIONS
  a_busy_held: assert property (@(posedge clk) disable iff (rst)
    busy |-> (fo.vld && q_full)) else $error("busy without a held beat");
`endif

endmodule

@@ sv/m3inv_queue.sv @@
// ---------------------------------------------------------------------------
// m3inv_queue: short queue between front and back
// Register FIFO; the back side drains one beat per cycle whenever non-empty.
// ---------------------------------------------------------------------------
module m3inv_queue import m3inv_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  front_beat_t  fi,
  output logic         full,
  output front_beat_t  qo
);

  q_item_t             mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                push, pop;

  assign full = (count == QCNT_W'(QDEPTH));
  assign push = fi.vld && !full;
  assign pop  = (count != '0);

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= fi.item;
  end

  assign qo.vld  = pop;
  assign qo.item = mem[rd_ptr];

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH)) else $error("queue overfilled");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    !rst |=> count == $past(count) + QCNT_W'($past(push)) - QCNT_W'($past(pop)))
    else $error("queue level mismatch");
`endif

endmodule

@@ sv/m3inv_back.sv @@
// ---------------------------------------------------------------------------
// m3inv_back: division and saturation pipeline
// Magnitudes, range precheck, one restoring quotient bit per stage for all
// nine entries, then sign, saturation and the singular case.
// ---------------------------------------------------------------------------
module m3inv_back import m3inv_pkg::*; (
  input  logic                            clk,
  input  logic                            rst,
  input  front_beat_t                     qi,
  output logic                            done,
  output logic [NENT-1:0][WORD_BITS-1:0]  inv,
  output logic                            singular,
  output logic                            overflow
);

  localparam logic [QB-1:0] QNEG_LIM = {{(QB-WORD_BITS){1'b0}}, 1'b1,
                                        {(WORD_BITS-1){1'b0}}};
  localparam logic [QB-1:0] QPOS_LIM = QNEG_LIM - 1'b1;

  // stage B0: magnitudes and signs
  logic                         v0, sing0;
  logic [DET_W-1:0]             d0;
  logic [NENT-1:0][COF_W-1:0]   mc0;
  logic [NENT-1:0]              neg0;

  // divider stages 0..QB
  logic                         vs   [QB+1];
  logic                         sgs  [QB+1];
  logic [DET_W-1:0]             ds   [QB+1];
  logic [NENT-1:0][DET_W-1:0]   rems [QB+1];
  logic [NENT-1:0][QB-1:0]      nlos [QB+1];
  logic [NENT-1:0][QB-1:0]      qs   [QB+1];
  logic [NENT-1:0]              pres [QB+1];
  logic [NENT-1:0]              negs [QB+1];

  logic [NUM_W-1:0]             num_b1 [NENT];
  logic                         ovf_any;
  logic [NENT-1:0][WORD_BITS-1:0] inv_next;

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      for (int s = 0; s <= QB; s++) vs[s] <= 1'b0;
      done <= 1'b0;
    end else begin
      v0    <= qi.vld;
      vs[0] <= v0;
      for (int s = 0; s < QB; s++) vs[s+1] <= vs[s];
      done  <= vs[QB];
    end
  end

  // B0: absolute values
  always_ff @(posedge clk) begin
    d0    <= qi.item.det[DET_W-1] ? (~qi.item.det + 1'b1) : qi.item.det;
    sing0 <= (qi.item.det == '0);
    for (int k = 0; k < NENT; k++) begin
      mc0[k]  <= qi.item.cof[k][COF_W-1] ? (~qi.item.cof[k] + 1'b1) : qi.item.cof[k];
      neg0[k] <= qi.item.cof[k][COF_W-1] ^ qi.item.det[DET_W-1];
    end
  end

  // scaled numerators
  always_comb begin
    for (int k = 0; k < NENT; k++) num_b1[k] = {mc0[k], {(2*FRAC_BITS){1'b0}}};
  end

  // B1: precheck quotient range, seed remainder;
  // then restoring division, one quotient bit per stage
  always_ff @(posedge clk) begin
    ds[0]  <= d0;
    sgs[0] <= sing0;
    for (int k = 0; k < NENT; k++) begin
      pres[0][k] <= (DET_W'(num_b1[k][NUM_W-1:QB]) >= d0);
      rems[0][k] <= DET_W'(num_b1[k][NUM_W-1:QB]);
      nlos[0][k] <= num_b1[k][QB-1:0];
      qs[0][k]   <= '0;
      negs[0][k] <= neg0[k];
    end
    for (int s = 0; s < QB; s++) begin
      logic [DET_W:0] tr;
      ds[s+1]   <= ds[s];
      sgs[s+1]  <= sgs[s];
      pres[s+1] <= pres[s];
      negs[s+1] <= negs[s];
      nlos[s+1] <= nlos[s];
      for (int k = 0; k < NENT; k++) begin
        tr = {rems[s][k], nlos[s][k][QB-1-s]};
        if (tr >= {1'b0, ds[s]}) begin
          rems[s+1][k] <= DET_W'(tr - {1'b0, ds[s]});
          qs[s+1][k]   <= qs[s][k] | (QB'(1) << (QB-1-s));
        end else begin
          rems[s+1][k] <= DET_W'(tr);
          qs[s+1][k]   <= qs[s][k];
        end
      end
    end
  end

  // sign, saturation, singular case
  always_comb begin
    ovf_any = 1'b0;
    for (int k = 0; k < NENT; k++) begin
      logic big, nz, ng;
      nz  = pres[QB][k] || (qs[QB][k] != '0);
      ng  = negs[QB][k] && nz;
      big = pres[QB][k] || (ng ? (qs[QB][k] > QNEG_LIM) : (qs[QB][k] > QPOS_LIM));
      if (sgs[QB]) begin
        inv_next[k] = '0;
      end else if (big) begin
        inv_next[k] = ng ? {1'b1, {(WORD_BITS-1){1'b0}}} : {1'b0, {(WORD_BITS-1){1'b1}}};
        ovf_any     = 1'b1;
      end else if (ng) begin
        inv_next[k] = ~qs[QB][k][WORD_BITS-1:0] + 1'b1;
      end else begin
        inv_next[k] = qs[QB][k][WORD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    inv      <= inv_next;
    singular <= sgs[QB];
    overflow <= ovf_any && !sgs[QB];
  end

`ifndef NO_ASSERTIONS
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(singular && overflow)) else $error("singular with overflow");
  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    (done && singular) |-> (inv == '0)) else $error("singular result not zero");
`endif

endmodule
